// File: hdl/sonar_window_min_grouper_macros.svh
// ---------------------------------------------------------------------------
// sonar_window_min_grouper_macros.svh
// assertion macros shared by the sonar window minimum grouper
// ---------------------------------------------------------------------------
`ifndef SONAR_WINDOW_MIN_GROUPER_MACROS_SVH
`define SONAR_WINDOW_MIN_GROUPER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SWMG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SWMG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/swmg_pkg.sv
// ---------------------------------------------------------------------------
// swmg_pkg
// types and constants of the sonar window minimum grouper
// ---------------------------------------------------------------------------
package swmg_pkg;

   // range cap in millimetres
   localparam logic [15:0] CAP_MM     = 16'd5675;
   localparam logic [12:0] CAP_MM_OUT = 13'd5675;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN  = 2'd2;

   // configuration reset values
   localparam logic [2:0] FRONT_COUNT_RESET = 3'd2;
   localparam logic [2:0] SIDE_COUNT_RESET  = 3'd2;
   localparam logic [3:0] WINDOW_LEN_RESET  = 4'd4;

   // request beat
   typedef struct packed {
      logic [2:0]  channel;
      logic [15:0] range_mm;
      logic        read_ok;
   } req_payload_type;

   // response beat
   typedef struct packed {
      logic        group;
      logic [12:0] min_distance_mm;
   } rsp_payload_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_FOLD,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic write;
      logic issue;
      logic fold;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_write;
      logic start_emit;
      logic last;
      logic rd_none;
      logic rd_last;
      logic out_free;
   } status_type;

endpackage

// File: hdl/swmg_ram.sv
// ---------------------------------------------------------------------------
// swmg_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module swmg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/swmg_ctrl.sv
// ---------------------------------------------------------------------------
// swmg_ctrl
// sequencer: accept, window write, window read sweep, fold, emit
// ---------------------------------------------------------------------------
module swmg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swmg_pkg::status_type  status,
   output swmg_pkg::cmd_type     cmd
);

   swmg_pkg::state_type state_ff;
   swmg_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swmg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         swmg_pkg::ST_IDLE: begin
            // no beat is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               if (status.start_write) begin
                  state_in = swmg_pkg::ST_WRITE;
               end else if (status.start_emit) begin
                  state_in = swmg_pkg::ST_EMIT;
               end
            end
         end
         swmg_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = status.rd_none ? swmg_pkg::ST_FOLD : swmg_pkg::ST_READ;
         end
         swmg_pkg::ST_READ: begin
            cmd.issue = 1'b1;
            if (status.rd_last) begin
               state_in = swmg_pkg::ST_DRAIN;
            end
         end
         swmg_pkg::ST_DRAIN: begin
            // last read data folds into the window minimum here
            state_in = swmg_pkg::ST_FOLD;
         end
         swmg_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = status.last ? swmg_pkg::ST_EMIT : swmg_pkg::ST_IDLE;
         end
         swmg_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = swmg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swmg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/swmg_datapath.sv
// ---------------------------------------------------------------------------
// swmg_datapath
// config registers, per-channel ring pointers, window store, minimum logic
// ---------------------------------------------------------------------------
`include "sonar_window_min_grouper_macros.svh"

module swmg_datapath #(
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_WINDOW   = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [swmg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [swmg_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  swmg_pkg::req_payload_type            req_payload,
   input  swmg_pkg::cmd_type                    cmd,
   output swmg_pkg::status_type                 status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output swmg_pkg::rsp_payload_type            rsp_payload
);

   localparam int CH_W      = $clog2(MAX_CHANNELS);
   localparam int SLOT_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W    = $clog2(MAX_WINDOW + 1);
   localparam int ADDR_W    = CH_W + SLOT_W;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(MAX_WINDOW - 1);
   localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(1 % MAX_WINDOW);
   localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(MAX_WINDOW);
   localparam logic [FILL_W-1:0] FILL_ONE   = FILL_W'(1);

   // configuration registers
   logic [2:0] front_count_ff;
   logic [2:0] side_count_ff;
   logic [3:0] window_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_count_ff <= swmg_pkg::FRONT_COUNT_RESET;
         side_count_ff  <= swmg_pkg::SIDE_COUNT_RESET;
         window_len_ff  <= swmg_pkg::WINDOW_LEN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            swmg_pkg::CSR_FRONT_COUNT: front_count_ff <= csr_wdata[2:0];
            swmg_pkg::CSR_SIDE_COUNT:  side_count_ff  <= csr_wdata[2:0];
            swmg_pkg::CSR_WINDOW_LEN:  window_len_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // request decode: group membership and last channel of the group
   logic [3:0] total_count;
   logic [3:0] ch_ext;
   logic [3:0] ch_plus;
   logic       in_range;
   logic       req_grp;
   logic       req_last;

   always_comb begin
      total_count = {1'b0, front_count_ff} + {1'b0, side_count_ff};
      ch_ext      = {1'b0, req_payload.channel};
      ch_plus     = ch_ext + 4'd1;
      in_range    = (32'(req_payload.channel) < MAX_CHANNELS) && (ch_ext < total_count);
      req_grp     = (req_payload.channel >= front_count_ff);
      req_last    = req_grp ? (ch_plus == total_count) : (ch_plus == {1'b0, front_count_ff});
   end

   // item registers
   logic [CH_W-1:0] ch_ff;
   logic [15:0]     range_ff;
   logic            grp_ff;
   logic            last_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff    <= CH_W'(req_payload.channel);
         range_ff <= req_payload.range_mm;
         grp_ff   <= req_grp;
         last_ff  <= req_last;
      end
   end

   // per-channel ring state
   logic [FILL_W-1:0]       fill_ff  [MAX_CHANNELS];
   logic [SLOT_W-1:0]       wslot_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] init_ff;

   logic [FILL_W-1:0] cur_fill;
   logic [SLOT_W-1:0] cur_slot;
   logic              cur_init;
   logic [FILL_W-1:0] fill_next;
   logic [FILL_W-1:0] eff_win;
   logic [FILL_W-1:0] win_count;
   logic [FILL_W-1:0] read_count;
   logic [SLOT_W-1:0] slot_next;
   logic [SLOT_W-1:0] slot_before;

   always_comb begin
      cur_fill  = fill_ff[ch_ff];
      cur_slot  = wslot_ff[ch_ff];
      cur_init  = init_ff[ch_ff];
      fill_next = (cur_fill < FILL_MAX) ? cur_fill + FILL_ONE : cur_fill;
      // zero acts as one, oversize clamps to the store depth
      if (window_len_ff == 4'd0) begin
         eff_win = FILL_ONE;
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         eff_win = FILL_MAX;
      end else begin
         eff_win = FILL_W'(window_len_ff);
      end
      win_count   = (fill_next < eff_win) ? fill_next : eff_win;
      // the fresh reading is already known, so only older entries are read
      read_count  = win_count - FILL_ONE;
      slot_next   = (cur_slot == SLOT_LAST) ? '0 : cur_slot + SLOT_W'(1);
      slot_before = (cur_slot == '0) ? SLOT_LAST : cur_slot - SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            fill_ff[c]  <= FILL_ONE;
            wslot_ff[c] <= SLOT_RESET;
         end
         init_ff <= '1;
      end else if (cmd.write) begin
         fill_ff[ch_ff]  <= fill_next;
         wslot_ff[ch_ff] <= slot_next;
         if (cur_slot == '0) begin
            init_ff[ch_ff] <= 1'b0;
         end
      end
   end

   // window store
   logic [15:0] ram_rdata;
   logic [SLOT_W-1:0] ptr_ff;

   swmg_ram #(
      .WIDTH (16),
      .DEPTH (RAM_DEPTH)
   ) u_window_store (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr ({ch_ff, cur_slot}),
      .wr_data (range_ff),
      .rd_en   (cmd.issue),
      .rd_addr ({ch_ff, ptr_ff}),
      .rd_data (ram_rdata)
   );

   // read sweep and window minimum
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] ptr_in;
   logic [15:0]       acc_ff, acc_in;
   logic              pend_ff, pend_in;
   logic              pend_init_ff, pend_init_in;
   logic [15:0]       rd_val;

   always_comb begin
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      acc_in       = acc_ff;
      pend_in      = 1'b0;
      pend_init_in = 1'b0;
      // slot 0 reads as the cap until it is first written
      rd_val       = pend_init_ff ? swmg_pkg::CAP_MM : ram_rdata;
      if (cmd.write) begin
         acc_in = range_ff;
         cnt_in = read_count;
         ptr_in = slot_before;
      end
      if (cmd.issue) begin
         cnt_in       = cnt_ff - FILL_ONE;
         ptr_in       = (ptr_ff == '0) ? SLOT_LAST : ptr_ff - SLOT_W'(1);
         pend_in      = 1'b1;
         pend_init_in = (ptr_ff == '0) && cur_init;
      end
      if (pend_ff && (rd_val < acc_ff)) begin
         acc_in = rd_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         pend_init_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         pend_init_ff <= pend_init_in;
      end
      cnt_ff <= cnt_in;
      ptr_ff <= ptr_in;
      acc_ff <= acc_in;
   end

   // running group minimum
   logic [12:0] group_min_ff, group_min_in;

   always_comb begin
      group_min_in = group_min_ff;
      if (cmd.fold && ({3'b000, group_min_ff} > acc_ff)) begin
         group_min_in = acc_ff[12:0];
      end
      if (cmd.emit) begin
         group_min_in = swmg_pkg::CAP_MM_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_min_ff <= swmg_pkg::CAP_MM_OUT;
      end else begin
         group_min_ff <= group_min_in;
      end
   end

   // response output register
   logic                      rsp_valid_ff;
   swmg_pkg::rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff.group           <= grp_ff;
         rsp_data_ff.min_distance_mm <= group_min_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // status to the sequencer
   always_comb begin
      status.start_write = in_range && req_payload.read_ok;
      status.start_emit  = in_range && !req_payload.read_ok && req_last;
      status.last        = last_ff;
      status.rd_none     = (read_count == '0);
      status.rd_last     = (cnt_ff == FILL_ONE);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // checks
   `SWMG_ASSERT_NOW(a_group_min_capped, 1'b1, group_min_ff <= swmg_pkg::CAP_MM_OUT, "group minimum above cap")
   `SWMG_ASSERT_NOW(a_emit_room, cmd.emit, !rsp_valid_ff || rsp_ready, "emit over a waiting beat")
   `SWMG_ASSERT_NEXT(a_emit_resets_min, cmd.emit, group_min_ff == swmg_pkg::CAP_MM_OUT, "group minimum not reset after emit")
   `SWMG_ASSERT_NOW(a_pend_follows_issue, pend_ff, $past(cmd.issue), "read data without a read")

endmodule

// File: hdl/sonar_window_min_grouper.sv
// ---------------------------------------------------------------------------
// sonar_window_min_grouper
// sliding window minimum per sonar channel, folded into per-group minima
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------
//   request  | req_valid, req_ready, req_payload       | valid / ready
//   response | rsp_valid, rsp_ready, rsp_payload       | valid / ready
//   csr      | csr_write_en, csr_index, csr_wdata      | write enable only
//
// a good read writes the window store and reads n - 1 older entries, with
// n = min(fill, window_len), one per cycle through the single read port of
// the window store, drains them if any and folds; closing a group adds an emit.
// a failed read only emits when it closes a group; an ignored channel is dropped.
// req_ready is low during reset and rises in the first cycle after it.
// a waiting response beat stalls the block only at its next group result.
// ---------------------------------------------------------------------------
module sonar_window_min_grouper #(
   parameter int MAX_CHANNELS = 8,
   parameter int MAX_WINDOW   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  swmg_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output swmg_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_write_en,
   input  logic [swmg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swmg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   swmg_pkg::cmd_type    cmd;
   swmg_pkg::status_type status;

   // sequencer
   swmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   swmg_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_WINDOW   (MAX_WINDOW)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_payload  (req_payload),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

// File: tb/sv/sonar_window_min_grouper_tb.sv
// ---------------------------------------------------------------------------
// sonar_window_min_grouper_tb
// self-checking bench for the sonar window minimum grouper
//
// a clocked driver feeds request beats from a queue that the stimulus
// process fills phase by phase; a clocked monitor drains response beats and
// compares them with the group minima predicted at each accepted request.
// register writes happen only while the block is idle, between phases.
// each phase runs whole sweeps with random readings, plus broken sweeps and
// stray channels; one long response hold-off backs the block up.
// ---------------------------------------------------------------------------
module sonar_window_min_grouper_tb;

   localparam int MAX_CH       = 8;
   localparam int MAX_WIN      = 8;
   localparam int PHASE_ITEMS  = 60;
   localparam int SETTLE       = 20;
   localparam int HOLD_AT      = 30;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 3000;
   localparam int SHOW_LIMIT   = 10;
   localparam int IDLE_PERCENT = 8;
   localparam logic [swmg_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   swmg_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   swmg_pkg::rsp_payload_type rsp_payload;
   logic csr_write_en = 1'b0;
   logic [swmg_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [swmg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sonar_window_min_grouper #(
      .MAX_CHANNELS(MAX_CH),
      .MAX_WINDOW(MAX_WIN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor copy of the register file
   logic [2:0] cfg_front;
   logic [2:0] cfg_side;
   logic [3:0] cfg_window;

   // predictor copy of the channel windows and the running minimum
   logic [15:0] ring_mm [MAX_CH][MAX_WIN];
   logic [3:0]  fill_cnt [MAX_CH];
   logic [2:0]  next_slot [MAX_CH];
   logic [15:0] run_min;

   swmg_pkg::req_payload_type readings_to_send [$];
   swmg_pkg::rsp_payload_type expected_minima [$];
   swmg_pkg::rsp_payload_type want_beat;

   int errors = 0;
   int beats_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit calm = 1'b0;
   int stall_cycles = 0;

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void reset_predictor();
      for (int c = 0; c < MAX_CH; c++) begin
         for (int s = 0; s < MAX_WIN; s++) ring_mm[c][s] = '0;
         ring_mm[c][0] = swmg_pkg::CAP_MM;
         fill_cnt[c]   = 4'd1;
         next_slot[c]  = 3'd1;
      end
      run_min    = swmg_pkg::CAP_MM;
      cfg_front  = swmg_pkg::FRONT_COUNT_RESET;
      cfg_side   = swmg_pkg::SIDE_COUNT_RESET;
      cfg_window = swmg_pkg::WINDOW_LEN_RESET;
   endfunction

   // fold one accepted reading, queue a group minimum when a group closes
   function automatic void fold_reading(input swmg_pkg::req_payload_type rd);
      int total;
      int ch;
      int w;
      int n;
      int idx;
      bit last;
      logic grp;
      logic [15:0] m;
      swmg_pkg::rsp_payload_type beat;
      total = int'(cfg_front) + int'(cfg_side);
      ch = int'(rd.channel);
      if (ch >= MAX_CH || ch >= total) return;
      if (ch < int'(cfg_front)) begin
         grp  = 1'b0;
         last = (ch + 1 == int'(cfg_front));
      end else begin
         grp  = 1'b1;
         last = (ch + 1 == total);
      end
      if (rd.read_ok) begin
         ring_mm[ch][next_slot[ch]] = rd.range_mm;
         next_slot[ch] = 3'((int'(next_slot[ch]) + 1) % MAX_WIN);
         if (fill_cnt[ch] < MAX_WIN) fill_cnt[ch] = fill_cnt[ch] + 4'd1;
         // zero acts as one, oversize clips to the store depth
         w = int'(cfg_window);
         if (w == 0) w = 1;
         if (w > MAX_WIN) w = MAX_WIN;
         n = (int'(fill_cnt[ch]) < w) ? int'(fill_cnt[ch]) : w;
         m = 16'hFFFF;
         for (int k = 0; k < n; k++) begin
            idx = (int'(next_slot[ch]) + MAX_WIN - 1 - k) % MAX_WIN;
            if (ring_mm[ch][idx] < m) m = ring_mm[ch][idx];
         end
         if (m < run_min) run_min = m;
      end
      if (!last) return;
      beat.group = grp;
      beat.min_distance_mm = run_min[12:0];
      expected_minima = {expected_minima, beat};
      run_min = swmg_pkg::CAP_MM;
   endfunction

   function automatic void add_reading(input int ch, input logic [15:0] mm, input bit ok);
      swmg_pkg::req_payload_type rd;
      rd.channel  = 3'(ch);
      rd.range_mm = mm;
      rd.read_ok  = ok;
      readings_to_send = {readings_to_send, rd};
   endfunction

   // readings weighted toward the cap and toward short range
   function automatic logic [15:0] pick_range();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 20) return 16'($urandom);
      if (r < 70) return 16'($urandom_range(6000));
      if (r < 85) return 16'($urandom_range(5680, 5670));
      if (r < 95) return 16'($urandom_range(40));
      return (r < 97) ? 16'h0000 : 16'hFFFF;
   endfunction

   // mostly whole ascending sweeps, some broken sweeps and stray channels
   function automatic void queue_random_phase(input int target);
      int total;
      int counted;
      int kind;
      int skip;
      int cut;
      int c;
      total = int'(cfg_front) + int'(cfg_side);
      if (total > MAX_CH) total = MAX_CH;
      counted = 0;
      while (counted < target) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            for (int k = 0; k < total; k++) add_reading(k, pick_range(), $urandom_range(9) != 0);
            counted += total;
         end else if (kind < 90) begin
            skip = $urandom_range(total - 1);
            cut  = $urandom_range(total, 1);
            for (int k = 0; k < cut; k++) begin
               if (k != skip) begin
                  add_reading(k, pick_range(), 1'($urandom_range(1)));
                  counted++;
               end
            end
         end else begin
            repeat ($urandom_range(4, 1)) begin
               c = $urandom_range(MAX_CH - 1);
               add_reading(c, 16'($urandom), 1'($urandom_range(1)));
               if (c < total) counted++;
            end
         end
      end
   endfunction

   task automatic csr_write(input logic [swmg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [swmg_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         swmg_pkg::CSR_FRONT_COUNT: cfg_front = data[2:0];
         swmg_pkg::CSR_SIDE_COUNT:  cfg_side = data[2:0];
         swmg_pkg::CSR_WINDOW_LEN:  cfg_window = data;
         default: ;
      endcase
   endtask

   // wait until every reading is taken and every minimum has come back
   task automatic drain();
      @(negedge clock);
      while (readings_to_send.size() != 0 || req_valid || expected_minima.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic [3:0] front, input logic [3:0] side,
                            input logic [3:0] window, input bit quiet);
      csr_write(swmg_pkg::CSR_FRONT_COUNT, front);
      csr_write(swmg_pkg::CSR_SIDE_COUNT, side);
      csr_write(swmg_pkg::CSR_WINDOW_LEN, window);
      calm = quiet;
      queue_random_phase(PHASE_ITEMS);
      drain();
      calm = 1'b0;
   endtask

   // stimulus
   initial begin
      reset_predictor();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed sweeps under the reset settings
      add_reading(0, 16'd0, 1'b1);
      add_reading(1, 16'hFFFF, 1'b1);
      // failed reads still close their group
      add_reading(2, 16'd5676, 1'b0);
      add_reading(3, 16'd5674, 1'b0);
      add_reading(2, 16'd5676, 1'b1);
      add_reading(3, 16'd5674, 1'b1);
      // channels outside every group
      add_reading(7, 16'd0, 1'b1);
      add_reading(4, 16'd0, 1'b1);
      add_reading(5, 16'd1, 1'b0);
      // out of order: side reading folds into the front result
      add_reading(3, 16'd100, 1'b1);
      add_reading(2, 16'd6000, 1'b1);
      add_reading(1, 16'hFFFF, 1'b1);
      add_reading(0, 16'd0, 1'b0);
      add_reading(1, 16'd0, 1'b0);
      // wrap one ring past its depth
      for (int k = 0; k < 9; k++) add_reading(0, 16'(5675 + k - 4), 1'b1);
      add_reading(1, 16'd5675, 1'b1);
      drain();

      // settings sweep, extremes first
      run_phase(4'd1, 4'd1, 4'd1, 1'b0);
      run_phase(4'd7, 4'd1, 4'd8, 1'b0);
      run_phase(4'd8, 4'd3, 4'd15, 1'b1);
      run_phase(4'd4, 4'd0, 4'd0, 1'b0);
      csr_write(CSR_SPARE, 4'($urandom));
      run_phase(4'd3, 4'd5, 4'd9, 1'b0);
      run_phase(4'd7, 4'd7, 4'd5, 1'b0);
      run_phase(4'd2, 4'd6, 4'd2, 1'b0);
      repeat (2) begin
         logic [3:0] f;
         f = 4'($urandom_range(7, 1));
         run_phase(f, 4'($urandom_range(8 - int'(f), 1)), 4'($urandom_range(8, 1)), 1'b0);
      end

      if (errors == 0 && expected_minima.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) fold_reading(req_payload);
         if (!req_valid || req_ready) begin
            if (readings_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_valid   <= 1'b1;
               req_payload <= readings_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (expected_minima.size() == 0) begin
               errors++;
               if (errors <= SHOW_LIMIT)
                  $display("unexpected beat: group %0d min %0d",
                           rsp_payload.group, rsp_payload.min_distance_mm);
            end else begin
               want_beat = expected_minima.pop_front();
               if (want_beat.group != rsp_payload.group ||
                   want_beat.min_distance_mm != rsp_payload.min_distance_mm) begin
                  errors++;
                  if (errors <= SHOW_LIMIT)
                     $display("mismatch: expected group %0d min %0d, got group %0d min %0d",
                              want_beat.group, want_beat.min_distance_mm,
                              rsp_payload.group, rsp_payload.min_distance_mm);
               end
            end
         end
         // random stalls, with one long hold-off once HOLD_AT beats are seen
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && beats_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule
